// ----- rtl/tapc_pkg.sv -----
`default_nettype none
package tapc_pkg;

    // fixed field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_W       = 16;
    localparam int ERR_W        = SAMPLE_WIDTH + 1;
    localparam int DER_W        = ERR_W + 1;
    localparam int SUM_W        = 32;
    localparam int DRIVE_W      = 32;
    localparam int AXES         = 3;
    localparam int AXIS_W       = $clog2(AXES);
    localparam int PROP_W       = GAIN_W + ERR_W;
    localparam int INTEG_W      = GAIN_W + SUM_W;
    localparam int DERP_W       = GAIN_W + DER_W;
    localparam int ACC_W        = INTEG_W + 2;

    // axis order within a word
    localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

    // configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_GAIN_PROP  = 2'd0;
    localparam cfg_idx_t CFG_GAIN_INTEG = 2'd1;
    localparam cfg_idx_t CFG_GAIN_DERIV = 2'd2;

    // input word
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] pitch_target;
        logic signed [SAMPLE_WIDTH-1:0] pitch_measured;
        logic signed [SAMPLE_WIDTH-1:0] roll_target;
        logic signed [SAMPLE_WIDTH-1:0] roll_measured;
        logic signed [SAMPLE_WIDTH-1:0] yaw_target;
        logic signed [SAMPLE_WIDTH-1:0] yaw_measured;
    } tapc_in_t;

    // result word
    typedef struct packed {
        logic signed [DRIVE_W-1:0] pitch_drive;
        logic signed [DRIVE_W-1:0] roll_drive;
        logic signed [DRIVE_W-1:0] yaw_drive;
    } tapc_out_t;

    // per-axis terms handed from front to back
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [SUM_W-1:0] sum;
        logic signed [DER_W-1:0] der;
    } axis_terms_t;

    typedef struct packed {
        axis_terms_t [AXES-1:0] axis;
    } q_entry_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // saturate the integral update to 32 bits
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        if (v[SUM_W] == v[SUM_W-1]) begin
            r = v[SUM_W-1:0];
        end else if (v[SUM_W]) begin
            r = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SUM_W-1){1'b1}}};
        end
        return r;
    endfunction

    // saturate the full-precision drive to 32 bits
    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [DRIVE_W-1:0] r;
        if ((&v[ACC_W-1:DRIVE_W-1]) || !(|v[ACC_W-1:DRIVE_W-1])) begin
            r = v[DRIVE_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tapc_front.sv -----
`default_nettype none
module tapc_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire tapc_pkg::tapc_in_t  s_data,
    output logic                     push,
    output tapc_pkg::q_entry_t       push_entry,
    input  wire tapc_pkg::q_stat_t   q_stat
);
    import tapc_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] tgt  [AXES];
    logic signed [SAMPLE_WIDTH-1:0] meas [AXES];
    logic signed [SUM_W-1:0]        sum_reg  [AXES];
    logic signed [SUM_W-1:0]        sum_next [AXES];
    logic signed [ERR_W-1:0]        prev_reg [AXES];
    logic signed [ERR_W-1:0]        err      [AXES];
    logic signed [SUM_W:0]          sum_wide [AXES];
    logic signed [DER_W-1:0]        der      [AXES];

    // take a word whenever the queue has room
    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // unpack the word per axis
    always_comb begin
        tgt[0]  = s_data.pitch_target;
        meas[0] = s_data.pitch_measured;
        tgt[1]  = s_data.roll_target;
        meas[1] = s_data.roll_measured;
        tgt[2]  = s_data.yaw_target;
        meas[2] = s_data.yaw_measured;
    end

    // error, saturating integral and derivative per axis
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            err[a]      = ERR_W'(tgt[a]) - ERR_W'(meas[a]);
            sum_wide[a] = (SUM_W + 1)'(sum_reg[a]) + (SUM_W + 1)'(err[a]);
            sum_next[a] = sat_sum(sum_wide[a]);
            der[a]      = DER_W'(prev_reg[a]) - DER_W'(err[a]);
            push_entry.axis[a].err = err[a];
            push_entry.axis[a].sum = sum_next[a];
            push_entry.axis[a].der = der[a];
        end
    end

    // per-axis loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a]  <= '0;
                prev_reg[a] <= '0;
            end
        end else if (push) begin
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a]  <= sum_next[a];
                prev_reg[a] <= err[a];
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tapc_queue.sv -----
`default_nettype none
module tapc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire tapc_pkg::q_entry_t  push_entry,
    input  wire logic                pop,
    output tapc_pkg::q_entry_t       head,
    output tapc_pkg::q_stat_t        q_stat
);
    import tapc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tapc_back.sv -----
`default_nettype none
module tapc_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tapc_pkg::q_entry_t    head,
    input  wire tapc_pkg::q_stat_t     q_stat,
    output logic                       pop,
    input  wire logic                  cfg_we,
    input  wire tapc_pkg::cfg_idx_t    cfg_index,
    input  wire logic [15:0]           cfg_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output tapc_pkg::tapc_out_t        m_data
);
    import tapc_pkg::*;

    logic signed [GAIN_W-1:0]  gain_prop_reg;
    logic signed [GAIN_W-1:0]  gain_integ_reg;
    logic signed [GAIN_W-1:0]  gain_deriv_reg;

    logic [AXIS_W-1:0]         axis_reg;
    axis_terms_t               cur;
    logic                      mul_go;
    logic                      s1_adv;

    logic signed [PROP_W-1:0]  p_prop_next;
    logic signed [INTEG_W-1:0] p_integ_next;
    logic signed [DERP_W-1:0]  p_deriv_next;
    logic signed [PROP_W-1:0]  p_prop_reg;
    logic signed [INTEG_W-1:0] p_integ_reg;
    logic signed [DERP_W-1:0]  p_deriv_reg;
    logic [AXIS_W-1:0]         p_axis_reg;
    logic                      p_valid_reg;

    logic                      out_free;
    logic                      s2_go;
    logic                      s2_last;
    logic signed [ACC_W-1:0]   total;
    logic signed [DRIVE_W-1:0] drive;
    logic signed [DRIVE_W-1:0] asm_reg [AXES-1];
    logic                      m_valid_reg;
    tapc_out_t                 m_data_reg;

    // gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                CFG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                CFG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: three multipliers, one axis per unstalled cycle
    assign cur          = head.axis[axis_reg];
    assign s1_adv       = !p_valid_reg || s2_go;
    assign mul_go       = !q_stat.empty && s1_adv;
    assign pop          = mul_go && (axis_reg == AXIS_LAST);
    assign p_prop_next  = gain_prop_reg * cur.err;
    assign p_integ_next = gain_integ_reg * cur.sum;
    assign p_deriv_next = gain_deriv_reg * cur.der;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg    <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            if (mul_go) begin
                axis_reg <= (axis_reg == AXIS_LAST) ? '0 : axis_reg + 1'b1;
            end
            if (s1_adv) begin
                p_valid_reg <= mul_go;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_go) begin
            p_prop_reg  <= p_prop_next;
            p_integ_reg <= p_integ_next;
            p_deriv_reg <= p_deriv_next;
            p_axis_reg  <= axis_reg;
        end
    end

    // stage 2: full-precision sum and saturation
    assign out_free = !m_valid_reg || m_ready;
    assign s2_last  = (p_axis_reg == AXIS_LAST);
    assign s2_go    = p_valid_reg && (!s2_last || out_free);
    assign total    = ACC_W'(p_prop_reg) + ACC_W'(p_integ_reg) + ACC_W'(p_deriv_reg);
    assign drive    = sat_drive(total);

    // collect the first axes, then load the output word
    always_ff @(posedge aclk) begin
        if (s2_go && !s2_last) begin
            asm_reg[p_axis_reg[AXIS_W-2:0]] <= drive;
        end
        if (s2_go && s2_last) begin
            m_data_reg.pitch_drive <= asm_reg[0];
            m_data_reg.roll_drive  <= asm_reg[1];
            m_data_reg.yaw_drive   <= drive;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_go && s2_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/three_axis_pid_controller_core.sv -----
`default_nettype none
// three-axis pid controller core
// input channel s_valid/s_ready/s_data: one word per control tick with a target
// and a measured value for pitch, roll and yaw
// result channel m_valid/m_ready/m_data: one word per input word with the
// saturated drive for each axis, in input order
// config port cfg_we/cfg_index/cfg_data: index 0 proportional, 1 integral,
// 2 derivative gain, written in one cycle while the core is idle; other
// indexes are dropped
// an accepted word waits in the queue, its axes then pass in turn through
// the product registers, and its drive word is registered into m_data with
// m_valid; the back end steps one set of three multipliers across the axes
// the front end updates the integrals and previous errors in the accept cycle
// and queues the terms; QUEUE_DEPTH words can wait between front and back
// reset clears gains, integrals, previous errors, the queue and m_valid
// when the receiver stalls, the result word holds, the back end finishes the
// next word up to its last axis, then the queue fills and s_ready drops
module three_axis_pid_controller_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tapc_pkg::tapc_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tapc_pkg::tapc_out_t       m_data,
    input  wire logic                 cfg_we,
    input  wire tapc_pkg::cfg_idx_t   cfg_index,
    input  wire logic [15:0]          cfg_data
);
    import tapc_pkg::*;

    logic     push;
    logic     pop;
    q_entry_t push_entry;
    q_entry_t head;
    q_stat_t  q_stat;

    // error and integral front end
    tapc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_entry (push_entry),
        .q_stat     (q_stat)
    );

    // term queue
    tapc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    // gain multiply and output back end
    tapc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // back end never pops an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    // full and empty never both
    assert property (@(posedge aclk) disable iff (!aresetn) q_stat.full |-> !q_stat.empty)
        else $error("queue status inconsistent");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tapc_pkg::*;

    localparam cfg_idx_t CFG_UNUSED = 2'd3;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 240;
    localparam int DIR_ROWS = 16;

    // one row of the directed table: gains, input word, optional fixed result
    typedef struct packed {
        logic signed [GAIN_W-1:0] gp;
        logic signed [GAIN_W-1:0] gi;
        logic signed [GAIN_W-1:0] gd;
        tapc_in_t                 word;
        logic                     known;
        tapc_out_t                want;
    } dir_row_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    tapc_in_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    tapc_out_t  m_data;
    logic       cfg_we    = 1'b0;
    cfg_idx_t   cfg_index = CFG_GAIN_PROP;
    logic [15:0] cfg_data = '0;

    // predictor state: gains, integrals and last errors per axis
    logic signed [GAIN_W-1:0] prop_gain  = '0;
    logic signed [GAIN_W-1:0] integ_gain = '0;
    logic signed [GAIN_W-1:0] deriv_gain = '0;
    logic signed [SUM_W-1:0]  integ_sum [AXES];
    logic signed [ERR_W-1:0]  last_err  [AXES];

    tapc_out_t drive_expected [$];
    int        fail_count = 0;
    int        idle_pct   = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // gains at reset are zero
        '{0, 0, 0, '{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}},
        // previous error starts at zero
        '{0, 0, 1, '{7, 2, 0, 0, -3, 4}, 1'b1, '{-5, 0, 7}},
        // integral carries on from the errors of the rows before
        '{0, 1, 0, '{1, 0, 0, 0, 0, 0}, 1'b1, '{6, 0, -7}},
        '{0, 0, 0, '{32767, -32768, -32768, 32767, 32767, 32767}, 1'b1, '{0, 0, 0}},
        '{1, 0, 0, '{32767, -32768, -32768, 32767, 100, -25}, 1'b1,
          '{65535, -65535, 125}},
        '{0, 0, 1, '{-32768, 32767, 32767, -32768, 5, 5}, 1'b1,
          '{131070, -131070, 125}},
        '{-32768, 0, 0, '{32767, -32768, -32768, 32767, 0, 0}, 1'b1,
          '{-2147450880, 2147450880, 0}},
        '{32767, 32767, 32767, '{-32768, 32767, 32767, -32768, -32768, -32768},
          1'b0, '{0, 0, 0}},
        '{32767, 32767, 32767, '{0, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0}},
        '{-32768, -32768, -32768, '{32767, -32768, -32768, 32767, 32767, -32768},
          1'b0, '{0, 0, 0}},
        '{-32768, -32768, -32768, '{-32768, 32767, 32767, -32768, -1, 0},
          1'b0, '{0, 0, 0}},
        // full error swings drive the derivative term past 32 bits
        '{0, 0, -32768, '{32767, -32768, -32768, 32767, 0, -1}, 1'b0, '{0, 0, 0}},
        '{0, 0, -32768, '{-32768, 32767, 32767, -32768, 0, 1}, 1'b0, '{0, 0, 0}},
        '{32767, -32768, 32767, '{12345, -23456, -1, 1, 32767, 0}, 1'b0, '{0, 0, 0}},
        '{-1, -1, -1, '{-1, -1, 0, -32768, -32768, 0}, 1'b0, '{0, 0, 0}},
        '{0, 0, 0, '{32767, 32767, -32768, -32768, 0, 32767}, 1'b1, '{0, 0, 0}}
    };

    three_axis_pid_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // clamp a full-precision value to signed 32 bits
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > DRIVE_MAX) begin
            return 32'sh7fffffff;
        end
        if (v < DRIVE_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // one axis of a control tick, updates that axis' integral and last error
    function automatic logic signed [31:0] axis_drive(input int a,
                                                      input logic signed [15:0] tgt,
                                                      input logic signed [15:0] meas);
        longint err;
        longint sum;
        longint der;
        longint acc;
        err = longint'(tgt) - longint'(meas);
        integ_sum[a] = clamp32(longint'(integ_sum[a]) + err);
        sum = longint'(integ_sum[a]);
        der = longint'(last_err[a]) - err;
        acc = longint'(prop_gain) * err + longint'(integ_gain) * sum
            + longint'(deriv_gain) * der;
        last_err[a] = err[ERR_W-1:0];
        return clamp32(acc);
    endfunction

    // drive word for one control tick
    function automatic tapc_out_t pid_drive_word(input tapc_in_t w);
        tapc_out_t r;
        r.pitch_drive = axis_drive(0, w.pitch_target, w.pitch_measured);
        r.roll_drive  = axis_drive(1, w.roll_target, w.roll_measured);
        r.yaw_drive   = axis_drive(2, w.yaw_target, w.yaw_measured);
        return r;
    endfunction

    // gap length: none unless an idle_pct draw hits, else mostly short, some medium, a few long
    function automatic int gap_len();
        int r;
        if ($urandom_range(99) >= idle_pct) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 75) begin
            return $urandom_range(3, 1);
        end else if (r < 95) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(80, 20);
    endfunction

    function automatic logic signed [15:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 50) begin
            return 16'($urandom);
        end else if (r < 65) begin
            case ($urandom_range(4))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sh0000;
                3: return 16'shffff;
                default: return 16'sh0001;
            endcase
        end
        return 16'($urandom_range(600) - 300);
    endfunction

    function automatic tapc_in_t rand_word();
        tapc_in_t w;
        w.pitch_target   = rand_sample();
        w.pitch_measured = ($urandom_range(9) == 0) ? w.pitch_target : rand_sample();
        w.roll_target    = rand_sample();
        w.roll_measured  = ($urandom_range(9) == 0) ? w.roll_target : rand_sample();
        w.yaw_target     = rand_sample();
        w.yaw_measured   = ($urandom_range(9) == 0) ? w.yaw_target : rand_sample();
        return w;
    endfunction

    function automatic logic signed [15:0] rand_gain();
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(4))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sh0000;
                3: return 16'shffff;
                default: return 16'sh0001;
            endcase
        end
        return 16'($urandom);
    endfunction

    // send one word after a gap, predict its drive on accept
    task automatic push_word(input tapc_in_t w, input int gap, input logic known,
                             input tapc_out_t want);
        tapc_out_t predicted;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = pid_drive_word(w);
        drive_expected.push_back(known ? want : predicted);
        @(negedge aclk);
    endtask

    // stop sending and wait until every drive word is out
    task automatic settle();
        s_valid <= 1'b0;
        while (drive_expected.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // write all three gains, then an unused index that must be dropped
    task automatic load_gains(input logic signed [15:0] gp, input logic signed [15:0] gi,
                              input logic signed [15:0] gd);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GAIN_PROP;
        cfg_data  <= gp;
        @(negedge aclk);
        cfg_index <= CFG_GAIN_INTEG;
        cfg_data  <= gi;
        @(negedge aclk);
        cfg_index <= CFG_GAIN_DERIV;
        cfg_data  <= gd;
        @(negedge aclk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(negedge aclk);
        cfg_we <= 1'b0;
        prop_gain  = gp;
        integ_gain = gi;
        deriv_gain = gd;
    endtask

    task automatic check_drive(input string axis, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, axis, want, got);
            fail_count++;
        end
    endtask

    // result side: random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    // compare each drive word with the oldest expectation
    always @(posedge aclk) begin
        tapc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_expected.size() == 0) begin
                $display("%0t: drive word with no expectation: %h", $time, m_data);
                fail_count++;
            end else begin
                want = drive_expected.pop_front();
                check_drive("pitch_drive", want.pitch_drive, m_data.pitch_drive);
                check_drive("roll_drive", want.roll_drive, m_data.roll_drive);
                check_drive("yaw_drive", want.yaw_drive, m_data.yaw_drive);
            end
        end
    end

    // stimulus
    initial begin
        int i;
        int n;
        for (i = 0; i < AXES; i++) begin
            integ_sum[i] = '0;
            last_err[i]  = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        idle_pct = 40;
        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].gp !== prop_gain || dir_rows[i].gi !== integ_gain
                    || dir_rows[i].gd !== deriv_gain) begin
                settle();
                load_gains(dir_rows[i].gp, dir_rows[i].gi, dir_rows[i].gd);
            end
            push_word(dir_rows[i].word, gap_len(), dir_rows[i].known, dir_rows[i].want);
        end

        // random phases with fresh gains
        for (i = 0; i < RAND_PHASES; i++) begin
            settle();
            load_gains(rand_gain(), rand_gain(), rand_gain());
            idle_pct = (i == 3) ? 0 : $urandom_range(60, 15);
            for (n = 0; n < PHASE_WORDS; n++) begin
                push_word(rand_word(), gap_len(), 1'b0, '0);
            end
        end

        settle();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && drive_expected.size() == 0) begin
            $display("three_axis_pid_controller_core regression: pass");
        end else begin
            $display("three_axis_pid_controller_core regression: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #50_000_000;
        $display("three_axis_pid_controller_core regression: fail");
        $finish;
    end

endmodule
